[rtl/vtbi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbi_pkg
// Shared types and constants of the per-vertex top-4 bone influence block.
// ----------------------------------------------------------------------------
package vtbi_pkg;

   // field widths of the item channels
   localparam int unsigned REQ_TYPE_W = 1;
   localparam int unsigned VERTEX_W   = 12;
   localparam int unsigned BONE_W     = 8;
   localparam int unsigned WEIGHT_W   = 17;

   // slots reported on a read response
   localparam int unsigned OUT_SLOTS = 4;

   // unity weight in 16-bit fraction fixed point
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD  = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ = 1'b1;

   // one slot: bone number and its weight
   typedef struct packed {
      logic [BONE_W-1:0]   bone;
      logic [WEIGHT_W-1:0] weight;
   } slot_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

[rtl/vtbi_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbi_req_if
// Request channel: add an influence to a vertex or read its slots.
// ----------------------------------------------------------------------------
interface vtbi_req_if;
   logic                               valid;
   logic                               ready;
   logic [vtbi_pkg::REQ_TYPE_W-1:0]    req_type;
   logic [vtbi_pkg::VERTEX_W-1:0]      vertex_id;
   logic [vtbi_pkg::BONE_W-1:0]        bone_id;
   logic [vtbi_pkg::WEIGHT_W-1:0]      weight;

   modport source (output valid, req_type, vertex_id, bone_id, weight, input ready);
   modport sink   (input valid, req_type, vertex_id, bone_id, weight, output ready);
endinterface

[rtl/vtbi_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbi_rsp_if
// Response channel: the four reported slots of one vertex.
// ----------------------------------------------------------------------------
interface vtbi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vtbi_pkg::BONE_W-1:0]   slot0_bone;
   logic [vtbi_pkg::BONE_W-1:0]   slot1_bone;
   logic [vtbi_pkg::BONE_W-1:0]   slot2_bone;
   logic [vtbi_pkg::BONE_W-1:0]   slot3_bone;
   logic [vtbi_pkg::WEIGHT_W-1:0] slot0_weight;
   logic [vtbi_pkg::WEIGHT_W-1:0] slot1_weight;
   logic [vtbi_pkg::WEIGHT_W-1:0] slot2_weight;
   logic [vtbi_pkg::WEIGHT_W-1:0] slot3_weight;

   modport source (output valid, slot0_bone, slot1_bone, slot2_bone, slot3_bone,
                   slot0_weight, slot1_weight, slot2_weight, slot3_weight,
                   input ready);
   modport sink   (input valid, slot0_bone, slot1_bone, slot2_bone, slot3_bone,
                   slot0_weight, slot1_weight, slot2_weight, slot3_weight,
                   output ready);
endinterface

[rtl/vertex_top4_bone_influence.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_top4_bone_influence
// Per-vertex top-K bone influence selection over a row-wide slot memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  req_ch    in   valid/ready             req_type, vertex_id, bone_id, weight
//  rsp_ch    out  valid/ready, registered slot0..3 bone and weight
//
//  one item at a time: a row read of the single-port slot memory, then
//  the compare and write back (add) or the load of the response register (read)
//  after reset a clearing pass zeroes the min(NUM_VERTICES, 4096) rows of the
//  memory, one row a cycle; no item is taken during it
//  a held response stalls only a read item in its lookup state; adds go on
// ----------------------------------------------------------------------------
module vertex_top4_bone_influence #(
   parameter int unsigned NUM_VERTICES     = 4096,
   parameter int unsigned SLOTS_PER_VERTEX = 4,
   parameter int unsigned MAX_BONES        = 256
) (
   input  logic              clock,
   input  logic              reset,
   vtbi_req_if.sink          req_ch,
   vtbi_rsp_if.source        rsp_ch
);

   // rows addressable by the vertex field
   localparam int unsigned ADDR_SPAN = 2 ** vtbi_pkg::VERTEX_W;
   localparam int unsigned ROWS      = (NUM_VERTICES > ADDR_SPAN) ? ADDR_SPAN : NUM_VERTICES;
   localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned SLOT_W    = $clog2(SLOTS_PER_VERTEX);

   typedef vtbi_pkg::slot_type [SLOTS_PER_VERTEX-1:0] row_type;

   // slot memory, one row per vertex
   row_type row_mem [ROWS];

   vtbi_pkg::state_type state_ff, state_in;
   logic [ROW_W-1:0]    clear_ff, clear_in;

   // captured request
   logic [vtbi_pkg::REQ_TYPE_W-1:0] type_ff;
   logic [ROW_W-1:0]                row_ff;
   logic [vtbi_pkg::BONE_W-1:0]     bone_ff;
   logic [vtbi_pkg::WEIGHT_W-1:0]   weight_ff;
   logic                            vtx_ok_ff;
   logic                            bone_ok_ff;

   row_type rd_row_ff;

   // response register
   logic                                          out_valid_ff, out_valid_in;
   vtbi_pkg::slot_type [vtbi_pkg::OUT_SLOTS-1:0]  out_slots_ff, out_slots_in;

   // memory port and control
   logic             mem_we;
   logic [ROW_W-1:0] mem_waddr;
   row_type          mem_wdata;
   logic             accept;
   logic             rsp_load;
   logic             rsp_free;
   logic             clear_last;

   // search result
   logic [SLOT_W-1:0]             pick;
   logic [vtbi_pkg::WEIGHT_W-1:0] min_weight;
   row_type                       upd_row;
   logic [vtbi_pkg::WEIGHT_W-1:0] sat_weight;

   assign accept     = req_ch.valid && req_ch.ready;
   assign rsp_free   = !out_valid_ff || rsp_ch.ready;
   assign clear_last = (clear_ff == ROW_W'(ROWS - 1));

   // saturate the incoming weight to one
   assign sat_weight = (req_ch.weight > vtbi_pkg::WEIGHT_ONE) ? vtbi_pkg::WEIGHT_ONE
                                                              : req_ch.weight;

   // smallest stored weight, lowest slot on a tie
   always_comb begin
      pick       = '0;
      min_weight = rd_row_ff[0].weight;
      for (int s = 1; s < int'(SLOTS_PER_VERTEX); s++) begin
         if (rd_row_ff[s].weight < min_weight) begin
            pick       = SLOT_W'(s);
            min_weight = rd_row_ff[s].weight;
         end
      end
   end

   // row with the new influence in the picked slot, if it wins
   always_comb begin
      upd_row = rd_row_ff;
      if (weight_ff > min_weight) begin
         upd_row[pick].bone   = bone_ff;
         upd_row[pick].weight = weight_ff;
      end
   end

   // reported slots, zero beyond the row or for a vertex out of range
   for (genvar o = 0; o < int'(vtbi_pkg::OUT_SLOTS); o++) begin : g_out
      if (o < int'(SLOTS_PER_VERTEX)) begin : g_slot
         assign out_slots_in[o] = vtx_ok_ff ? rd_row_ff[o] : '0;
      end else begin : g_none
         assign out_slots_in[o] = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vtbi_pkg::ST_CLEAR: begin
            if (clear_last) state_in = vtbi_pkg::ST_IDLE;
         end
         vtbi_pkg::ST_IDLE: begin
            if (req_ch.valid) state_in = vtbi_pkg::ST_LOOKUP;
         end
         vtbi_pkg::ST_LOOKUP: begin
            if (type_ff == vtbi_pkg::REQ_ADD || rsp_free) state_in = vtbi_pkg::ST_IDLE;
         end
         default: state_in = vtbi_pkg::ST_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = row_ff;
      mem_wdata    = upd_row;
      rsp_load     = 1'b0;
      clear_in     = clear_ff;
      unique case (state_ff)
         vtbi_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_ff;
            mem_wdata = '0;
            clear_in  = clear_ff + ROW_W'(1);
         end
         vtbi_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         vtbi_pkg::ST_LOOKUP: begin
            if (type_ff == vtbi_pkg::REQ_ADD) begin
               mem_we = vtx_ok_ff && bone_ok_ff;
            end else begin
               rsp_load = rsp_free;
            end
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // response valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_load)          out_valid_in = 1'b1;
      else if (rsp_ch.ready) out_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vtbi_pkg::ST_CLEAR;
         clear_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff    <= req_ch.req_type;
         row_ff     <= req_ch.vertex_id[ROW_W-1:0];
         bone_ff    <= req_ch.bone_id;
         weight_ff  <= sat_weight;
         vtx_ok_ff  <= (32'(req_ch.vertex_id) < 32'(NUM_VERTICES));
         bone_ok_ff <= (32'(req_ch.bone_id) < 32'(MAX_BONES));
      end
   end

   // slot memory: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) row_mem[mem_waddr] <= mem_wdata;
      if (accept) rd_row_ff <= row_mem[req_ch.vertex_id[ROW_W-1:0]];
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) out_slots_ff <= out_slots_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.slot0_bone   = out_slots_ff[0].bone;
   assign rsp_ch.slot1_bone   = out_slots_ff[1].bone;
   assign rsp_ch.slot2_bone   = out_slots_ff[2].bone;
   assign rsp_ch.slot3_bone   = out_slots_ff[3].bone;
   assign rsp_ch.slot0_weight = out_slots_ff[0].weight;
   assign rsp_ch.slot1_weight = out_slots_ff[1].weight;
   assign rsp_ch.slot2_weight = out_slots_ff[2].weight;
   assign rsp_ch.slot3_weight = out_slots_ff[3].weight;

   // an accepted item always moves on to its lookup state
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == vtbi_pkg::ST_LOOKUP)
      else $error("accepted item did not reach lookup");

   // a response appears only after the lookup of a read item
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == vtbi_pkg::ST_LOOKUP
                                    && type_ff == vtbi_pkg::REQ_READ))
      else $error("response without a read item");

   // no memory write can collide with the row read of a new item
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != vtbi_pkg::ST_IDLE)
      else $error("slot memory written while idle");

   // stored weights never exceed one
   a_weight_sat: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == vtbi_pkg::ST_LOOKUP) |-> weight_ff <= vtbi_pkg::WEIGHT_ONE)
      else $error("unsaturated weight written");

endmodule
